// File: rtl/bounded_damped_return_step_macros.svh
// Assertion macros used by the checker file of the return-step block.
`ifndef BOUNDED_DAMPED_RETURN_STEP_MACROS_SVH
`define BOUNDED_DAMPED_RETURN_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BDRS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BDRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bdrs_pkg.sv
// Shared types, constants and fixed-point helpers of the return-step block.
package bdrs_pkg;

	localparam int unsigned DataW    = 32;
	localparam int unsigned StepW    = 17;
	localparam int unsigned LimW     = 31;
	localparam int unsigned DampW    = 25;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned NumStages = 7;
	localparam int unsigned CntW     = $clog2(NumStages + 1);

	typedef logic signed [DataW-1:0] q16_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		RegPosLimit   = 3'd0,
		RegSpringAccel = 3'd1,
		RegVelLimit   = 3'd2,
		RegDampCoef   = 3'd3,
		RegDampAccel  = 3'd4
	} cfg_reg_t;

	localparam q16_t MinQ = q16_t'(32'h8000_0000);
	localparam q16_t MaxQ = q16_t'(32'h7FFF_FFFF);

	// Settle thresholds: 0.25 on the value, 1.0 on the rate
	localparam logic [DataW-1:0] SettleValue = 32'h0000_4000;
	localparam logic [DataW-1:0] SettleRate  = 32'h0001_0000;

	// Saturate a 33-bit signed sum to 32 bits.
	function automatic q16_t sat33(input logic signed [DataW:0] x);
		if (x[DataW] != x[DataW-1]) begin
			return x[DataW] ? MinQ : MaxQ;
		end
		return x[DataW-1:0];
	endfunction

	// Finish a Q16.16 product: drop 16 fraction bits of the magnitude,
	// apply the sign, saturate.
	function automatic q16_t qfin(input logic [63:0] prod, input logic neg);
		logic [47:0] m;
		m = prod[63:16];
		if (neg) begin
			if (m > 48'h0000_8000_0000) begin
				return MinQ;
			end
			return q16_t'(-m[DataW-1:0]);
		end
		if (m > 48'h0000_7FFF_FFFF) begin
			return MaxQ;
		end
		return q16_t'(m[DataW-1:0]);
	endfunction

	// Magnitude of a signed word as unsigned (the minimum maps to 2^31).
	function automatic logic [DataW-1:0] mag32(input q16_t x);
		return x[DataW-1] ? (-x[DataW-1:0]) : x[DataW-1:0];
	endfunction

endpackage

// File: rtl/bdrs_ifs.sv
// Valid/ready channel interfaces: step request, step result, register write.
interface bdrs_in_if import bdrs_pkg::*; ();
	logic             valid;
	logic             ready;
	q16_t             value_in;
	q16_t             rate_in;
	logic [StepW-1:0] step_time;

	modport source(output valid, value_in, rate_in, step_time, input ready);
	modport sink(input valid, value_in, rate_in, step_time, output ready);
endinterface

interface bdrs_out_if import bdrs_pkg::*; ();
	logic valid;
	logic ready;
	q16_t value_out;
	q16_t rate_out;
	logic settled;

	modport source(output valid, value_out, rate_out, settled, input ready);
	modport sink(input valid, value_out, rate_out, settled, output ready);
endinterface

interface bdrs_cfg_if import bdrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [DataW-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/bounded_damped_return_step.sv
// Damped return-to-zero step, signed Q16.16, as a seven-stage pipeline.
//
//   channel  role    beat payload
//   req      sink    value_in, rate_in, step_time
//   rsp      source  value_out, rate_out, settled
//   cfg      sink    index, data (always ready, one write per beat)
//
// One beat per cycle in and out while rsp is not stalled; a result passes through registers s1 to s7 to rsp.
// Depth is set by the two multiply stages (dt products, then rate * damping)
// with the adds and clamps between and after them.
// arst_n clears the valid bits and loads the register reset values.
// A stalled rsp holds its beat; earlier stages keep filling bubbles.
module bounded_damped_return_step import bdrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bdrs_in_if.sink    req,
	bdrs_out_if.source rsp,
	bdrs_cfg_if.sink   cfg
);

	// Configuration registers
	logic [LimW-1:0]  pos_limit_q;
	logic [LimW-1:0]  spring_accel_q;
	logic [LimW-1:0]  vel_limit_q;
	logic [DampW-1:0] damp_coef_q;
	logic [LimW-1:0]  damp_accel_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_limit_q    <= '1;
			spring_accel_q <= '0;
			vel_limit_q    <= '1;
			damp_coef_q    <= '0;
			damp_accel_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				RegPosLimit:    pos_limit_q    <= cfg.data[LimW-1:0];
				RegSpringAccel: spring_accel_q <= cfg.data[LimW-1:0];
				RegVelLimit:    vel_limit_q    <= cfg.data[LimW-1:0];
				RegDampCoef:    damp_coef_q    <= cfg.data[DampW-1:0];
				RegDampAccel:   damp_accel_q   <= cfg.data[LimW-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic stl_s1, stl_s2, stl_s3, stl_s4, stl_s5, stl_s6, stl_s7;
	q16_t v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	q16_t r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7;
	logic [48:0] pr_s1;
	logic        neg_s1;
	logic [47:0] ps_s1;
	logic [41:0] pk_s1;
	logic [47:0] pf_s1;
	logic [LimW-1:0] s_s2;
	logic [25:0]     k_s2, k_s3;
	logic [LimW-1:0] f_s2, f_s3, f_s4, f_s5;
	logic [57:0]     prk_s4;
	logic            neg_s4;

	// Stage advance: a stage loads when it is empty or its successor moves
	logic [NumStages:1] adv;

	always_comb begin
		adv[7] = !vld_s7 || rsp.ready;
		adv[6] = !vld_s6 || adv[7];
		adv[5] = !vld_s5 || adv[6];
		adv[4] = !vld_s4 || adv[5];
		adv[3] = !vld_s3 || adv[4];
		adv[2] = !vld_s2 || adv[3];
		adv[1] = !vld_s1 || adv[2];
	end

	assign req.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= req.valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: settle test and the four dt products
	logic [DataW-1:0] mag_v_c, mag_r_c;
	logic             settle_c;
	logic [48:0]      pr_c;
	logic [47:0]      ps_c, pf_c;
	logic [41:0]      pk_c;

	always_comb begin
		mag_v_c  = mag32(req.value_in);
		mag_r_c  = mag32(req.rate_in);
		settle_c = (mag_v_c < SettleValue) && (mag_r_c < SettleRate);
		pr_c = {17'b0, mag_r_c} * {32'b0, req.step_time};
		ps_c = {17'b0, spring_accel_q} * {31'b0, req.step_time};
		pf_c = {17'b0, damp_accel_q} * {31'b0, req.step_time};
		pk_c = {17'b0, damp_coef_q} * {25'b0, req.step_time};
	end

	// Stage 2: integrate the value and bound it; zero a rate pushing past the bound
	q16_t                   dv_c, vsum_c, v2_c, r2_c;
	logic signed [DataW:0]  vadd_c, vext_c, plim_c;
	logic [63:0]            s_full_c, f_full_c;
	logic [LimW-1:0]        s2_c, f2_c;

	always_comb begin
		dv_c   = qfin({15'b0, pr_s1}, neg_s1);
		vadd_c = {v_s1[DataW-1], v_s1} + {dv_c[DataW-1], dv_c};
		vsum_c = sat33(vadd_c);
		vext_c = {vsum_c[DataW-1], vsum_c};
		plim_c = {2'b00, pos_limit_q};
		v2_c   = vsum_c;
		r2_c   = r_s1;
		if (vext_c > plim_c) begin
			v2_c = q16_t'(plim_c[DataW-1:0]);
			if (!r_s1[DataW-1] && (r_s1 != '0)) r2_c = '0;
		end else if (vext_c < -plim_c) begin
			v2_c = q16_t'(-plim_c[DataW-1:0]);
			if (r_s1[DataW-1]) r2_c = '0;
		end
		// dt products are never negative; saturation keeps them below 2^31
		s_full_c = 64'(qfin({16'b0, ps_s1}, 1'b0));
		f_full_c = 64'(qfin({16'b0, pf_s1}, 1'b0));
		s2_c     = s_full_c[LimW-1:0];
		f2_c     = f_full_c[LimW-1:0];
	end

	// Stage 3: restoring acceleration against the sign of the value
	logic signed [DataW:0] r3_sum_c;
	q16_t                  r3_c;

	always_comb begin
		r3_sum_c = {r_s2[DataW-1], r_s2};
		if (!v_s2[DataW-1] && (v_s2 != '0)) begin
			r3_sum_c = {r_s2[DataW-1], r_s2} - {2'b00, s_s2};
		end else if (v_s2[DataW-1]) begin
			r3_sum_c = {r_s2[DataW-1], r_s2} + {2'b00, s_s2};
		end
		r3_c = sat33(r3_sum_c);
	end

	// Stage 4: rate times damping factor
	logic [DataW-1:0] mag_r3_c;
	logic [57:0]      prk_c;

	always_comb begin
		mag_r3_c = mag32(r_s3);
		prk_c    = {26'b0, mag_r3_c} * {32'b0, k_s3};
	end

	// Stage 5: subtract the damping term
	q16_t                  dq_c, r5_c;
	logic signed [DataW:0] r5_sum_c;

	always_comb begin
		dq_c     = qfin({6'b0, prk_s4}, neg_s4);
		r5_sum_c = {r_s4[DataW-1], r_s4} - {dq_c[DataW-1], dq_c};
		r5_c     = sat33(r5_sum_c);
	end

	// Stage 6: friction pull that stops at zero
	logic signed [DataW:0] r6_sum_c;
	q16_t                  r6_c;

	always_comb begin
		if (!r_s5[DataW-1] && (r_s5 != '0)) begin
			r6_sum_c = {r_s5[DataW-1], r_s5} - {2'b00, f_s5};
			if (r6_sum_c[DataW]) r6_sum_c = '0;
		end else begin
			r6_sum_c = {r_s5[DataW-1], r_s5} + {2'b00, f_s5};
			if (!r6_sum_c[DataW] && (r6_sum_c != '0)) r6_sum_c = '0;
		end
		r6_c = r6_sum_c[DataW-1:0];
	end

	// Stage 7: rate bound, settled beats forced to zero
	logic signed [DataW:0] r7_ext_c, vlim_c;
	q16_t                  r7_c, v7_c;

	always_comb begin
		r7_ext_c = {r_s6[DataW-1], r_s6};
		vlim_c   = {2'b00, vel_limit_q};
		r7_c     = r_s6;
		if (r7_ext_c > vlim_c) begin
			r7_c = q16_t'(vlim_c[DataW-1:0]);
		end else if (r7_ext_c < -vlim_c) begin
			r7_c = q16_t'(-vlim_c[DataW-1:0]);
		end
		v7_c = v_s6;
		if (stl_s6) begin
			v7_c = '0;
			r7_c = '0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			stl_s1 <= settle_c;
			v_s1   <= req.value_in;
			r_s1   <= req.rate_in;
			pr_s1  <= pr_c;
			neg_s1 <= req.rate_in[DataW-1];
			ps_s1  <= ps_c;
			pk_s1  <= pk_c;
			pf_s1  <= pf_c;
		end
		if (adv[2]) begin
			stl_s2 <= stl_s1;
			v_s2   <= v2_c;
			r_s2   <= r2_c;
			s_s2   <= s2_c;
			k_s2   <= pk_s1[41:16];
			f_s2   <= f2_c;
		end
		if (adv[3]) begin
			stl_s3 <= stl_s2;
			v_s3   <= v_s2;
			r_s3   <= r3_c;
			k_s3   <= k_s2;
			f_s3   <= f_s2;
		end
		if (adv[4]) begin
			stl_s4 <= stl_s3;
			v_s4   <= v_s3;
			r_s4   <= r_s3;
			prk_s4 <= prk_c;
			neg_s4 <= r_s3[DataW-1];
			f_s4   <= f_s3;
		end
		if (adv[5]) begin
			stl_s5 <= stl_s4;
			v_s5   <= v_s4;
			r_s5   <= r5_c;
			f_s5   <= f_s4;
		end
		if (adv[6]) begin
			stl_s6 <= stl_s5;
			v_s6   <= v_s5;
			r_s6   <= r6_c;
		end
		if (adv[7]) begin
			stl_s7 <= stl_s6;
			v_s7   <= v7_c;
			r_s7   <= r7_c;
		end
	end

	assign rsp.valid     = vld_s7;
	assign rsp.value_out = v_s7;
	assign rsp.rate_out  = r_s7;
	assign rsp.settled   = stl_s7;

endmodule

// File: rtl/bdrs_chk.sv
// Port-level checker for the return-step block, bound to the top level.
`include "bounded_damped_return_step_macros.svh"

module bdrs_chk import bdrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input q16_t value_out,
	input q16_t rate_out,
	input logic settled
);

	// Beats accepted but not yet delivered
	logic [CntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CntW'(req_valid && req_ready) - CntW'(rsp_valid && rsp_ready);
		end
	end

	`BDRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(value_out) && $stable(rate_out) && $stable(settled), "stalled result beat changed")
	`BDRS_ASSERT(a_settled_zero, rsp_valid && settled, value_out == '0 && rate_out == '0, "settled beat carries nonzero value or rate")
	`BDRS_ASSERT(a_bounds_sym, rsp_valid, value_out != MinQ && rate_out != MinQ, "result outside symmetric bound")
	`BDRS_ASSERT(a_no_orphan, rsp_valid, cnt_q != '0, "result beat without a pending request")
	`BDRS_ASSERT(a_depth, req_valid && req_ready, cnt_q != CntW'(NumStages) || (rsp_valid && rsp_ready), "more beats in flight than stages")

endmodule

bind bounded_damped_return_step bdrs_chk u_bdrs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.value_out (rsp.value_out),
	.rate_out  (rsp.rate_out),
	.settled   (rsp.settled)
);
